// ===== src/upfa_pkg.sv =====
// ----------------------------------------------------------------------------
// upfa_pkg: payload frame assembler types and constants
// Field widths, status and packet-kind codes, and the beat/state structs.
// ----------------------------------------------------------------------------
package upfa_pkg;

    localparam int HEADER_BYTES      = 12;
    localparam int PAYLOAD_BYTES     = 2048;
    localparam int FRAME_BYTES_RESET = 640 * 480;

    localparam int HLEN_W  = 8;
    localparam int FLAGS_W = 8;
    localparam int PTS_W   = 32;
    localparam int PLEN_W  = 12;
    localparam int FILL_W  = 20;
    localparam int WLEN_W  = 11;
    localparam int ERRC_W  = 16;
    localparam int STAT_W  = 4;

    // header flag bit positions
    localparam int FLAG_FID = 0;
    localparam int FLAG_EOF = 1;
    localparam int FLAG_PTS = 2;
    localparam int FLAG_ERR = 6;

    typedef enum logic [STAT_W-1:0] {
        ST_START     = 4'd0,
        ST_APPEND    = 4'd1,
        ST_DONE      = 4'd2,
        ST_IGNORED   = 4'd3,
        ST_BADHDR    = 4'd4,
        ST_STREAMERR = 4'd5,
        ST_NOPTS     = 4'd6,
        ST_MISMATCH  = 4'd7,
        ST_OVERFLOW  = 4'd8
    } t_status;

    typedef enum logic [1:0] {
        K_DISCARD = 2'd0,
        K_FIRST   = 2'd1,
        K_INTER   = 2'd2,
        K_LAST    = 2'd3
    } t_kind;

    typedef struct packed {
        logic [HLEN_W-1:0]  header_length;
        logic [FLAGS_W-1:0] header_flags;
        logic [PTS_W-1:0]   pts;
        logic [PLEN_W-1:0]  payload_size;
    } t_item;

    typedef struct packed {
        t_status            status;
        logic               write_enable;
        logic [FILL_W-1:0]  write_offset;
        logic [WLEN_W-1:0]  write_len;
        logic               frame_done;
        logic [ERRC_W-1:0]  error_count;
    } t_result;

    typedef struct packed {
        logic [PTS_W-1:0]   prev_ts;
        logic               prev_fid;
        logic [FILL_W-1:0]  fill;
        t_kind              kind;
        logic [ERRC_W-1:0]  err_cnt;
    } t_state;

endpackage

// ===== src/upfa_if.sv =====
// ----------------------------------------------------------------------------
// upfa_if: channel interfaces of the payload frame assembler
// Payload descriptor in, assembly decision out, frame size config write.
// ----------------------------------------------------------------------------
interface upfa_in_if;
    import upfa_pkg::*;
    logic               valid;
    logic               ready;
    logic [HLEN_W-1:0]  header_length;
    logic [FLAGS_W-1:0] header_flags;
    logic [PTS_W-1:0]   pts;
    logic [PLEN_W-1:0]  payload_size;

    modport source (output valid, header_length, header_flags, pts, payload_size,
                    input ready);
    modport sink   (input valid, header_length, header_flags, pts, payload_size,
                    output ready);
endinterface

interface upfa_out_if;
    import upfa_pkg::*;
    logic               valid;
    logic               ready;
    logic [STAT_W-1:0]  status;
    logic               write_enable;
    logic [FILL_W-1:0]  write_offset;
    logic [WLEN_W-1:0]  write_len;
    logic               frame_done;
    logic [ERRC_W-1:0]  error_count;

    modport source (output valid, status, write_enable, write_offset, write_len,
                    frame_done, error_count, input ready);
    modport sink   (input valid, status, write_enable, write_offset, write_len,
                    frame_done, error_count, output ready);
endinterface

interface upfa_cfg_if;
    import upfa_pkg::*;
    logic              valid;
    logic              ready;
    logic [FILL_W-1:0] frame_bytes;

    modport source (output valid, frame_bytes, input ready);
    modport sink   (input valid, frame_bytes, output ready);
endinterface

// ===== src/upfa_decide.sv =====
// ----------------------------------------------------------------------------
// upfa_decide: per-payload header check and frame placement
// Combinational next-state and result for one registered descriptor.
// ----------------------------------------------------------------------------
module upfa_decide (
    input  upfa_pkg::t_item                  i_item,
    input  upfa_pkg::t_state                 i_state,
    input  logic [upfa_pkg::FILL_W-1:0]      i_frame_bytes,
    output upfa_pkg::t_state                 o_state,
    output upfa_pkg::t_result                o_result
);
    import upfa_pkg::*;

    logic [PLEN_W-1:0] len_sat;
    logic [WLEN_W-1:0] data_len;
    logic              hdr_bad;
    logic              new_frame;
    logic [FILL_W:0]   fill_sum;
    logic [FILL_W:0]   fb_ext;

    // oversized payloads clip to the max payload size
    assign len_sat  = (i_item.payload_size > PLEN_W'(PAYLOAD_BYTES))
                    ? PLEN_W'(PAYLOAD_BYTES) : i_item.payload_size;
    assign hdr_bad  = (i_item.header_length != HLEN_W'(HEADER_BYTES))
                   || (len_sat < PLEN_W'(HEADER_BYTES));
    assign data_len = WLEN_W'(len_sat - PLEN_W'(HEADER_BYTES));
    assign new_frame = (i_item.pts != i_state.prev_ts)
                    || (i_item.header_flags[FLAG_FID] != i_state.prev_fid);
    assign fill_sum = {1'b0, i_state.fill} + (FILL_W+1)'(data_len);
    assign fb_ext   = {1'b0, i_frame_bytes};

    always_comb begin
        o_state                 = i_state;
        o_result.status         = ST_IGNORED;
        o_result.write_enable   = 1'b0;
        o_result.write_offset   = '0;
        o_result.write_len      = '0;
        o_result.frame_done     = 1'b0;

        if (hdr_bad || i_item.header_flags[FLAG_ERR] || !i_item.header_flags[FLAG_PTS]) begin
            // error paths: drop an in-progress frame, keep fill
            if (hdr_bad) begin
                o_result.status = ST_BADHDR;
            end else if (i_item.header_flags[FLAG_ERR]) begin
                o_result.status = ST_STREAMERR;
                if (i_state.err_cnt != '1) begin
                    o_state.err_cnt = i_state.err_cnt + 1'b1;
                end
            end else begin
                o_result.status = ST_NOPTS;
            end
            if (i_state.kind inside {K_FIRST, K_INTER}) begin
                o_state.kind = K_DISCARD;
            end
        end else if (new_frame) begin
            o_state.prev_ts  = i_item.pts;
            o_state.prev_fid = i_item.header_flags[FLAG_FID];
            o_state.fill     = '0;
            o_state.kind     = K_FIRST;
            o_result.status  = ST_START;
            if (data_len != '0) begin
                if ((FILL_W+1)'(data_len) > fb_ext) begin
                    o_state.kind    = K_DISCARD;
                    o_result.status = ST_OVERFLOW;
                end else begin
                    o_result.write_enable = 1'b1;
                    o_result.write_len    = data_len;
                    o_state.fill          = FILL_W'(data_len);
                end
            end
        end else if (i_item.header_flags[FLAG_EOF]) begin
            o_state.prev_ts = '0;
            if (fill_sum != fb_ext) begin
                o_result.status = ST_MISMATCH;
                if (i_state.kind inside {K_FIRST, K_INTER}) begin
                    o_state.kind = K_DISCARD;
                end
            end else begin
                case (i_state.kind)
                    K_DISCARD: begin
                        // exact end seen while dropping: resync, no handoff
                        o_state.kind = K_LAST;
                        o_state.fill = '0;
                    end
                    K_LAST: begin
                        o_state.kind = K_LAST;
                    end
                    default: begin
                        o_result.status     = ST_DONE;
                        o_result.frame_done = 1'b1;
                        if (data_len != '0) begin
                            o_result.write_enable = 1'b1;
                            o_result.write_offset = i_state.fill;
                            o_result.write_len    = data_len;
                        end
                        o_state.kind = K_LAST;
                        o_state.fill = '0;
                    end
                endcase
            end
        end else begin
            if (!(i_state.kind inside {K_DISCARD, K_LAST})) begin
                o_result.status = ST_APPEND;
                o_state.kind    = K_INTER;
                if (data_len != '0) begin
                    if (fill_sum > fb_ext) begin
                        o_state.kind    = K_DISCARD;
                        o_state.fill    = '0;
                        o_result.status = ST_OVERFLOW;
                    end else begin
                        o_result.write_enable = 1'b1;
                        o_result.write_offset = i_state.fill;
                        o_result.write_len    = data_len;
                        o_state.fill          = fill_sum[FILL_W-1:0];
                    end
                end
            end
        end

        o_result.error_count = o_state.err_cnt;
    end

endmodule

// ===== src/uvc_payload_frame_assembler_core.sv =====
// ----------------------------------------------------------------------------
// uvc_payload_frame_assembler_core: payload header check and frame assembly
// Path: an accepted descriptor is held in the descriptor register, then its result beat in the result register.
// Throughput: 1 descriptor per cycle while results are taken; the stream state updates with each decision.
// Reset: synchronous, active low; frame size returns to 640x480 bytes, state
// clears to discard, ready is held low while reset is asserted.
// ----------------------------------------------------------------------------
module uvc_payload_frame_assembler_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    upfa_in_if.sink       i_item,
    upfa_cfg_if.sink      i_cfg,
    upfa_out_if.source    o_result
);
    import upfa_pkg::*;

    // descriptor register
    logic              r_in_valid;
    t_item             r_item;

    // stream state and frame size register
    t_state            r_state;
    t_state            n_state;
    logic [FILL_W-1:0] r_frame_bytes;

    // result register
    logic              r_out_valid;
    t_result           r_result;
    t_result           n_result;

    logic              out_adv;
    logic              in_take;
    logic              step;

    // Result register empties or drains this cycle -> descriptor can move on,
    // so the input side stalls only while a descriptor sits behind a stalled result.
    assign out_adv = !r_out_valid || o_result.ready;
    assign step    = r_in_valid && out_adv;

    assign i_item.ready = i_rst_n && (!r_in_valid || out_adv);
    assign in_take      = i_item.valid && i_item.ready;

    // user must write config only while idle (not enforced here); always ready out of reset
    assign i_cfg.ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_bytes <= FILL_W'(FRAME_BYTES_RESET);
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_frame_bytes <= i_cfg.frame_bytes;
        end
    end

    // stage 1: capture the descriptor beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_item.header_length <= i_item.header_length;
            r_item.header_flags  <= i_item.header_flags;
            r_item.pts           <= i_item.pts;
            r_item.payload_size  <= i_item.payload_size;
        end
    end

    // decision logic; state feeds straight back so each beat sees the last
    upfa_decide u_decide (
        .i_item        (r_item),
        .i_state       (r_state),
        .i_frame_bytes (r_frame_bytes),
        .o_state       (n_state),
        .o_result      (n_result)
    );

    // stage 2: commit state and result together
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.prev_ts  <= '0;
            r_state.prev_fid <= 1'b0;
            r_state.fill     <= '0;
            r_state.kind     <= K_DISCARD;
            r_state.err_cnt  <= '0;
        end else if (step) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_result <= n_result;
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.status       = r_result.status;
    assign o_result.write_enable = r_result.write_enable;
    assign o_result.write_offset = r_result.write_offset;
    assign o_result.write_len    = r_result.write_len;
    assign o_result.frame_done   = r_result.frame_done;
    assign o_result.error_count  = r_result.error_count;

endmodule

// ===== src/upfa_checker.sv =====
// ----------------------------------------------------------------------------
// upfa_checker: port-level checks for the payload frame assembler
// Watches the descriptor and result channels; bound to the core below.
// ----------------------------------------------------------------------------
module upfa_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic [upfa_pkg::STAT_W-1:0]   i_status,
    input  logic                          i_write_enable,
    input  logic [upfa_pkg::FILL_W-1:0]   i_write_offset,
    input  logic [upfa_pkg::WLEN_W-1:0]   i_write_len,
    input  logic                          i_frame_done,
    input  logic [upfa_pkg::ERRC_W-1:0]   i_error_count
);
    import upfa_pkg::*;

    logic [ERRC_W-1:0] r_last_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_err <= '0;
        end else if (i_out_valid && i_out_ready) begin
            r_last_err <= i_error_count;
        end
    end

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_status) && $stable(i_write_enable)
            && $stable(i_write_offset) && $stable(i_write_len)
            && $stable(i_frame_done) && $stable(i_error_count))
        else $error("result beat changed while stalled");

    // saturating error count never goes backwards across beats
    a_err_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_error_count >= r_last_err)
        else $error("error count decreased");

    // an idle result side wakes up only for a descriptor accepted earlier and held in the descriptor register
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready, 2))
        else $error("result beat without a descriptor");

    // a handed-off frame is always reported as completed
    a_done_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_frame_done |-> i_status == STAT_W'(ST_DONE))
        else $error("frame done with wrong status");

endmodule

bind uvc_payload_frame_assembler_core upfa_checker u_upfa_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_item.valid),
    .i_in_ready     (i_item.ready),
    .i_out_valid    (o_result.valid),
    .i_out_ready    (o_result.ready),
    .i_status       (o_result.status),
    .i_write_enable (o_result.write_enable),
    .i_write_offset (o_result.write_offset),
    .i_write_len    (o_result.write_len),
    .i_frame_done   (o_result.frame_done),
    .i_error_count  (o_result.error_count)
);

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: payload frame assembler testbench
// Sends payload descriptors through the core with random idle bursts on
// both channels and predicts every decision beat in step with the stream
// state. Directed corner cases come first, then random frame sequences
// under several frame sizes, including zero and the largest size.
// ----------------------------------------------------------------------------
module tb;
    import upfa_pkg::*;

    // largest data part of one payload, header stripped
    localparam int unsigned MAX_DATA = PAYLOAD_BYTES - HEADER_BYTES;
    localparam int unsigned PLEN_MAX = (1 << PLEN_W) - 1;
    localparam int          PHASE_BEATS = 75;
    localparam int          DRAIN_LIMIT = 20000;

    // header flag masks
    localparam logic [FLAGS_W-1:0] F_FID = FLAGS_W'(1 << FLAG_FID);
    localparam logic [FLAGS_W-1:0] F_EOF = FLAGS_W'(1 << FLAG_EOF);
    localparam logic [FLAGS_W-1:0] F_PTS = FLAGS_W'(1 << FLAG_PTS);
    localparam logic [FLAGS_W-1:0] F_ERR = FLAGS_W'(1 << FLAG_ERR);

    logic i_clk = 1'b0;
    logic i_rst_n;

    upfa_in_if  item_bus ();
    upfa_out_if result_bus ();
    upfa_cfg_if cfg_bus ();

    uvc_payload_frame_assembler_core dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_bus),
        .i_cfg    (cfg_bus),
        .o_result (result_bus)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Stream state as the core should hold it
    // ------------------------------------------------------------------------
    logic [PTS_W-1:0]  asm_prev_pts;
    logic              asm_prev_fid;
    logic [FILL_W-1:0] asm_fill;
    t_kind             asm_kind;
    logic [ERRC_W-1:0] asm_err_cnt;
    logic [FILL_W-1:0] asm_frame_bytes;

    t_item   pending_payloads [$];     // descriptors not yet offered
    t_result expected_decisions [$];   // decisions owed by the core, oldest first

    int items_queued;
    int items_accepted = 0;
    int failures = 0;
    bit drain_stuck;
    int sizes_used;
    int status_hits [16] = '{default: 0};

    bit idle_on;                       // random idle bursts on both channels
    int src_gap;
    int sink_gap;
    t_item   next_payload;
    t_result oldest_decision;

    // generator memory, lets a new frame reuse the last timestamp
    logic [PTS_W-1:0] gen_last_pts;
    logic             gen_last_fid;

    logic [FILL_W-1:0] phase_sizes [6];

    // A stream fault drops a frame in progress; after a last packet or while
    // already discarding the kind stays where it is.
    function automatic t_status abandon_frame(input t_status why);
        if (asm_kind == K_FIRST || asm_kind == K_INTER)
            asm_kind = K_DISCARD;
        return why;
    endfunction

    // Place n data bytes of a first, inter or last payload into the frame.
    function automatic void place_data(input t_kind k, input int unsigned n,
                                       inout t_result r);
        if (k == K_FIRST) begin
            asm_fill = '0;
        end else if (asm_kind == K_DISCARD) begin
            // an exact end seen while discarding resyncs, but hands off nothing
            if (k == K_LAST) begin
                asm_kind = K_LAST;
                asm_fill = '0;
            end
            r.status = ST_IGNORED;
            return;
        end else if (asm_kind == K_LAST) begin
            r.status = ST_IGNORED;
            return;
        end
        case (k)
            K_FIRST: r.status = ST_START;
            K_LAST:  r.status = ST_DONE;
            default: r.status = ST_APPEND;
        endcase
        if (n > 0) begin
            if (asm_fill + n > asm_frame_bytes) begin
                k        = K_DISCARD;
                asm_fill = '0;
                r.status = ST_OVERFLOW;
            end else begin
                r.write_enable = 1'b1;
                r.write_offset = asm_fill;
                r.write_len    = WLEN_W'(n);
                asm_fill       = FILL_W'(asm_fill + n);
            end
        end
        asm_kind = k;
        if (k == K_LAST) begin
            asm_fill     = '0;
            r.frame_done = 1'b1;
        end
    endfunction

    // Decision for one accepted descriptor; advances the stream state.
    function automatic t_result assemble_payload(input t_item p);
        t_result     r;
        int unsigned len;
        int unsigned n;
        r        = '0;
        r.status = ST_IGNORED;
        len      = 32'(p.payload_size);
        if (len > PAYLOAD_BYTES)
            len = PAYLOAD_BYTES;
        if (p.header_length != HEADER_BYTES || len < HEADER_BYTES) begin
            r.status = abandon_frame(ST_BADHDR);
        end else if (p.header_flags[FLAG_ERR]) begin
            if (asm_err_cnt != '1)
                asm_err_cnt++;
            r.status = abandon_frame(ST_STREAMERR);
        end else if (!p.header_flags[FLAG_PTS]) begin
            r.status = abandon_frame(ST_NOPTS);
        end else begin
            n = len - HEADER_BYTES;
            if (p.pts != asm_prev_pts || p.header_flags[FLAG_FID] != asm_prev_fid) begin
                // new frame; an unfinished one is dropped first
                if (asm_kind == K_INTER)
                    asm_kind = K_DISCARD;
                asm_prev_pts = p.pts;
                asm_prev_fid = p.header_flags[FLAG_FID];
                place_data(K_FIRST, n, r);
            end else if (p.header_flags[FLAG_EOF]) begin
                asm_prev_pts = '0;
                if (asm_fill + n != asm_frame_bytes)
                    r.status = abandon_frame(ST_MISMATCH);
                else
                    place_data(K_LAST, n, r);
            end else begin
                place_data(K_INTER, n, r);
            end
        end
        r.error_count = asm_err_cnt;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Descriptor driver: offers queued beats, holds each until accepted,
    // and predicts the decision at the accepting edge.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            item_bus.valid <= 1'b0;
            src_gap = 0;
            asm_prev_pts = '0;
            asm_prev_fid = 1'b0;
            asm_fill     = '0;
            asm_kind     = K_DISCARD;
            asm_err_cnt  = '0;
        end else begin
            if (item_bus.valid && item_bus.ready) begin
                expected_decisions.push_back(assemble_payload(t_item'({
                    item_bus.header_length, item_bus.header_flags,
                    item_bus.pts, item_bus.payload_size})));
                items_accepted++;
            end
            // only move on once the current beat is gone
            if (!item_bus.valid || item_bus.ready) begin
                if (src_gap != 0) begin
                    src_gap--;
                    item_bus.valid <= 1'b0;
                end else if (idle_on && $urandom_range(0, 9) == 0) begin
                    src_gap = $urandom_range(0, 3);
                    item_bus.valid <= 1'b0;
                end else if (pending_payloads.size() != 0) begin
                    next_payload = pending_payloads.pop_front();
                    item_bus.header_length <= next_payload.header_length;
                    item_bus.header_flags  <= next_payload.header_flags;
                    item_bus.pts           <= next_payload.pts;
                    item_bus.payload_size  <= next_payload.payload_size;
                    item_bus.valid         <= 1'b1;
                end else begin
                    item_bus.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Decision monitor: random back-pressure, compares each beat with the
    // oldest prediction.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            result_bus.ready <= 1'b0;
            sink_gap = 0;
        end else begin
            if (result_bus.valid && result_bus.ready) begin
                status_hits[result_bus.status]++;
                if (expected_decisions.size() == 0) begin
                    $error("decision beat with no descriptor outstanding, status %0d",
                           result_bus.status);
                    failures++;
                end else begin
                    oldest_decision = expected_decisions.pop_front();
                    check_field("status", 32'(oldest_decision.status),
                                32'(result_bus.status));
                    check_field("write_enable", 32'(oldest_decision.write_enable),
                                32'(result_bus.write_enable));
                    check_field("write_offset", 32'(oldest_decision.write_offset),
                                32'(result_bus.write_offset));
                    check_field("write_len", 32'(oldest_decision.write_len),
                                32'(result_bus.write_len));
                    check_field("frame_done", 32'(oldest_decision.frame_done),
                                32'(result_bus.frame_done));
                    check_field("error_count", 32'(oldest_decision.error_count),
                                32'(result_bus.error_count));
                end
            end
            if (sink_gap != 0) begin
                sink_gap--;
                result_bus.ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                sink_gap = $urandom_range(0, 3);
                result_bus.ready <= 1'b0;
            end else begin
                result_bus.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic push_payload(input int unsigned hl, input logic [FLAGS_W-1:0] fl,
                                input logic [PTS_W-1:0] ts, input int unsigned pl);
        pending_payloads.push_back(t_item'({HLEN_W'(hl), fl, ts, PLEN_W'(pl)}));
        items_queued++;
    endtask

    // Block until every queued descriptor is in and every decision is out.
    task automatic wait_quiet();
        int guard;
        guard = 0;
        while ((items_accepted != items_queued || expected_decisions.size() != 0)
               && guard < DRAIN_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        if (guard >= DRAIN_LIMIT) begin
            $error("decisions stopped arriving, %0d outstanding",
                   expected_decisions.size());
            drain_stuck = 1'b1;
        end
    endtask

    // Only called with the core idle.
    task automatic write_frame_bytes(input logic [FILL_W-1:0] size);
        @(posedge i_clk);
        cfg_bus.frame_bytes <= size;
        cfg_bus.valid       <= 1'b1;
        do @(posedge i_clk); while (!cfg_bus.ready);
        asm_frame_bytes = size;
        cfg_bus.valid <= 1'b0;
        sizes_used++;
    endtask

    // One frame as a camera would send it: a start, some appends and an
    // exact end. Now and then a beat is spoiled or the frame is cut short.
    task automatic queue_frame(input int unsigned size, inout int budget);
        int unsigned        left;
        int unsigned        n;
        int unsigned        cap;
        int unsigned        pl;
        logic [PTS_W-1:0]   ts;
        logic [FLAGS_W-1:0] fl;
        logic [HLEN_W-1:0]  hl;
        logic               fid;
        bit                 first;
        bit                 closing;
        bit                 spoiled;
        bit                 short_len;
        // sometimes the same timestamp with the frame id flipped
        if ($urandom_range(0, 3) == 0) begin
            ts  = gen_last_pts;
            fid = !gen_last_fid;
        end else begin
            ts  = $urandom;
            fid = 1'($urandom_range(0, 1));
        end
        gen_last_pts = ts;
        gen_last_fid = fid;
        left  = size;
        first = 1'b1;
        while (budget > 0) begin
            cap       = (left < MAX_DATA) ? left : MAX_DATA;
            closing   = !first && left <= MAX_DATA && (left == 0 || $urandom_range(0, 2) == 0);
            n         = closing ? left : $urandom_range(0, cap);
            hl        = HLEN_W'(HEADER_BYTES);
            fl        = FLAGS_W'($urandom);
            fl[FLAG_FID] = fid;
            fl[FLAG_EOF] = closing;
            fl[FLAG_PTS] = 1'b1;
            fl[FLAG_ERR] = 1'b0;
            spoiled   = 1'b1;
            short_len = 1'b0;
            case ($urandom_range(0, 24))
                0: hl = HLEN_W'($urandom);
                1: short_len = 1'b1;
                2: fl[FLAG_ERR] = 1'b1;
                3: fl[FLAG_PTS] = 1'b0;
                4: if (left < MAX_DATA) n = $urandom_range(left + 1, MAX_DATA);
                5: if (closing && left > 0) n = $urandom_range(0, left - 1);
                6: return;   // frame cut short, the next one restarts
                default: spoiled = 1'b0;
            endcase
            if (short_len)
                pl = $urandom_range(0, HEADER_BYTES - 1);
            else if (n == MAX_DATA && $urandom_range(0, 1) == 1)
                pl = $urandom_range(PAYLOAD_BYTES, PLEN_MAX);   // clipped by the core
            else
                pl = n + HEADER_BYTES;
            push_payload(32'(hl), fl, ts, pl);
            budget--;
            first = 1'b0;
            if (!spoiled && n <= left)
                left -= n;
            if (closing)
                break;
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        int budget;
        int unsigned k;

        // everything known from time zero
        i_rst_n                 = 1'b0;
        cfg_bus.valid           = 1'b0;
        cfg_bus.frame_bytes     = '0;
        asm_frame_bytes = FILL_W'(FRAME_BYTES_RESET);
        gen_last_pts    = '0;
        gen_last_fid    = 1'b0;
        items_queued    = 0;
        drain_stuck     = 1'b0;
        sizes_used      = 0;
        idle_on = 1'b1;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // --- directed, at the reset frame size ---
        push_payload('0, '0, '0, 0);                                   // bad header, all zero
        push_payload('1, '1, '1, PLEN_MAX);                            // bad header, all ones
        push_payload(HEADER_BYTES, F_PTS, 1, HEADER_BYTES - 1);        // shorter than header
        push_payload(HEADER_BYTES, F_ERR | F_PTS, 2, HEADER_BYTES);    // error flag
        push_payload(HEADER_BYTES, '0, 3, 100);                        // no timestamp
        push_payload(HEADER_BYTES, F_PTS, 0, 50);                      // stale append
        push_payload(HEADER_BYTES, F_PTS | F_FID, 32'h1234_5678, PLEN_MAX); // start, clipped
        push_payload(HEADER_BYTES, F_PTS | F_FID, 32'h1234_5678, HEADER_BYTES); // empty append
        push_payload(HEADER_BYTES, F_PTS | F_FID, 32'h1234_5678, PAYLOAD_BYTES);
        push_payload(HEADER_BYTES, F_PTS, '1, HEADER_BYTES);           // restart mid frame
        push_payload(HEADER_BYTES, F_PTS, '1, 112);
        push_payload(HEADER_BYTES, F_PTS | F_EOF, '1, 20);             // end, wrong size
        wait_quiet();

        // --- directed, tiny frame ---
        write_frame_bytes(FILL_W'(40));
        push_payload(HEADER_BYTES, F_PTS | F_FID, 5, 32);
        push_payload(HEADER_BYTES, F_PTS | F_FID | F_EOF, 5, 17);      // short end, discard
        push_payload(HEADER_BYTES, F_PTS | F_FID | F_EOF, 0, 32);      // exact end while discarding
        push_payload(HEADER_BYTES, F_PTS | F_FID, 0, 40);              // append after last
        push_payload(HEADER_BYTES, F_PTS | F_FID | F_EOF, 0, 52);      // end after last
        push_payload(HEADER_BYTES, F_PTS, 7, 30);
        push_payload(HEADER_BYTES, F_PTS, 7, 22);
        push_payload(HEADER_BYTES, F_PTS | F_EOF, 7, 24);              // completes
        push_payload(HEADER_BYTES, F_PTS | F_FID, 8, 53);              // start overflows
        push_payload(HEADER_BYTES, 8'hB8 | F_PTS, 9, HEADER_BYTES);    // stray bits, no data
        push_payload(HEADER_BYTES, 8'hB8 | F_PTS | F_EOF, 9, 52);      // whole frame in one end
        push_payload(HEADER_BYTES, F_ERR | F_PTS | F_EOF | F_FID, 9, HEADER_BYTES);
        wait_quiet();

        // --- random phases; each pause also drains the pipe completely ---
        phase_sizes[0] = FILL_W'(1);
        phase_sizes[1] = '0;                       // out of range, used as is
        phase_sizes[2] = '1;
        phase_sizes[3] = FILL_W'($urandom_range(2, 300));
        phase_sizes[4] = FILL_W'($urandom_range(300, 6000));
        phase_sizes[5] = FILL_W'($urandom_range(2, 2000));
        foreach (phase_sizes[i]) begin
            if (i == 5)
                idle_on = 1'b0;                    // closing stretch at full rate
            write_frame_bytes(phase_sizes[i]);
            budget = PHASE_BEATS;
            while (budget > 0) begin
                if ($urandom_range(0, 9) == 0) begin
                    // noise; half of it with a valid header length
                    k = $urandom_range(0, 1);
                    push_payload(k ? HEADER_BYTES : $urandom_range(0, 255),
                                 FLAGS_W'($urandom), $urandom,
                                 $urandom_range(0, PLEN_MAX));
                    budget--;
                end else begin
                    queue_frame(phase_sizes[i], budget);
                end
            end
            wait_quiet();
        end

        repeat (8) @(posedge i_clk);

        $display("summary: %0d descriptors under %0d frame sizes; %0d frames done, %0d starts",
                 items_accepted, sizes_used + 1, status_hits[ST_DONE], status_hits[ST_START]);
        $display("summary: %0d overflows, %0d size mismatches, %0d ignored, %0d bad headers",
                 status_hits[ST_OVERFLOW], status_hits[ST_MISMATCH],
                 status_hits[ST_IGNORED], status_hits[ST_BADHDR]);
        if (failures == 0 && !drain_stuck)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // hard stop, far beyond any correct run
    initial begin
        #3_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/upfa_pkg.sv
src/upfa_if.sv
src/upfa_decide.sv
src/uvc_payload_frame_assembler_core.sv
src/upfa_checker.sv
test/tb.sv
